[hw/rtl/ahlt_pkg.sv]
// shared types and constants for the arp host learning table
package ahlt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [15:0] ARP_TYPE = 16'h0806;

    typedef struct packed {
        logic [15:0] frame_type;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] now_seconds;
    } ahlt_in_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] entry_index;
        logic [6:0] host_total;
        logic       dropped_full;
    } ahlt_out_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic commit;
    } ahlt_cmd_t;

    typedef struct packed {
        logic is_arp;
        logic match;
        logic miss;
        logic out_free;
    } ahlt_sts_t;

endpackage

[hw/rtl/ahlt_ctrl.sv]
// controller state machine for the arp host learning table
module ahlt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ahlt_pkg::ahlt_sts_t sts,
    output ahlt_pkg::ahlt_cmd_t cmd
);
    import ahlt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && sts.is_arp)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.scan = 1'b1;
                if (sts.match || sts.miss)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/ahlt_dp.sv]
// datapath for the arp host learning table: host stores, scan pointer, result register
module ahlt_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  ahlt_pkg::ahlt_in_t  in_data,
    input  ahlt_pkg::ahlt_cmd_t cmd,
    output ahlt_pkg::ahlt_sts_t sts,
    output logic                out_valid,
    input  logic                out_ready,
    output ahlt_pkg::ahlt_out_t out_data
);
    import ahlt_pkg::*;

    logic [31:0] ip_mem   [TABLE_DEPTH];
    logic [47:0] mac_mem  [TABLE_DEPTH];
    logic [31:0] seen_mem [TABLE_DEPTH];

    ahlt_in_t   word_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ptr_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg;
    logic [31:0]      rd_ip_reg;
    logic             res_hit_reg;
    logic [IDX_W-1:0] res_slot_reg;
    logic             out_valid_reg;
    ahlt_out_t        out_reg;

    logic             issue;
    logic             full;
    logic             match;
    logic [CNT_W-1:0] count_next;
    ahlt_out_t        out_next;

    assign issue = cmd.scan && (ptr_reg < count_reg);
    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign match = cmp_valid_reg && (rd_ip_reg == word_reg.src_ip);

    assign sts.is_arp   = (in_data.frame_type == ARP_TYPE);
    assign sts.match    = match;
    assign sts.miss     = !match && (ptr_reg == count_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // table read, one entry per cycle
    always_ff @(posedge clk)
    begin
        rd_ip_reg <= ip_mem[ptr_reg[IDX_W-1:0]];
        if (cmd.commit)
        begin
            if (res_hit_reg)
            begin
                seen_mem[res_slot_reg] <= word_reg.now_seconds;
            end
            else if (!full)
            begin
                ip_mem[count_reg[IDX_W-1:0]]   <= word_reg.src_ip;
                mac_mem[count_reg[IDX_W-1:0]]  <= word_reg.src_mac;
                seen_mem[count_reg[IDX_W-1:0]] <= word_reg.now_seconds;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= in_data;
        end
        if (issue)
        begin
            cmp_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.decide)
        begin
            res_hit_reg  <= match;
            res_slot_reg <= cmp_idx_reg;
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        count_next            = count_reg;
        out_next.hit          = res_hit_reg;
        out_next.entry_index  = 6'(res_slot_reg);
        out_next.dropped_full = 1'b0;
        if (!res_hit_reg)
        begin
            if (full)
            begin
                out_next.entry_index  = '0;
                out_next.dropped_full = 1'b1;
            end
            else
            begin
                out_next.entry_index = 6'(count_reg[IDX_W-1:0]);
                count_next           = count_reg + 1'b1;
            end
        end
        out_next.host_total = 7'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg <= '0;
            end
            else if (issue)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            cmp_valid_reg <= issue;
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("host count above table depth");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg))
        else $error("host count changed without commit");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare on entry beyond host count");

endmodule

[hw/rtl/arp_host_learning_table_core.sv]
// top level of the arp host learning table
//
//  channel  direction  handshake             word
//  in       input      in_valid / in_ready   frame_type, src_ip, src_mac, now_seconds
//  out      output     out_valid / out_ready hit, entry_index, host_total, dropped_full
//
// an arp word is searched from entry 0 up to the first match or to the host count: one table
// entry is compared per cycle through the single read port of the ip store, then the result
// is committed
// non-arp words are taken without a search and give no result
// reset clears the host count and the handshake state; stores are not cleared
// a waiting result does not block the next input; a search that ends while the
// previous result is still held waits for out_ready
module arp_host_learning_table_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ahlt_pkg::ahlt_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ahlt_pkg::ahlt_out_t out_data
);
    import ahlt_pkg::*;

    ahlt_cmd_t cmd;
    ahlt_sts_t sts;

    ahlt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ahlt_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[dv/arp_host_learning_table_core_tb.sv]
// self-checking testbench for the arp host learning table core
`timescale 1ns / 100ps

module arp_host_learning_table_core_tb;

    import ahlt_pkg::*;

    class host_table_scoreboard;
        logic [31:0]  ip_tab   [TABLE_DEPTH];
        logic [47:0]  mac_tab  [TABLE_DEPTH];
        logic [31:0]  seen_tab [TABLE_DEPTH];
        int unsigned  hosts;
        ahlt_out_t    expected_q[$];
        int unsigned  errors;
        int unsigned  refreshes;
        int unsigned  learned;
        int unsigned  drops;
        int unsigned  others;
        int unsigned  checked;

        function void note_frame(ahlt_in_t w);
            ahlt_out_t   r;
            int unsigned slot;
            bit          found;
            bit          dropped;
            found   = 1'b0;
            dropped = 1'b0;
            slot    = 0;
            if (w.frame_type != ARP_TYPE)
            begin
                others++;
                return;
            end
            for (int i = 0; i < hosts; i++)
            begin
                if (!found && ip_tab[i] == w.src_ip)
                begin
                    found = 1'b1;
                    slot  = i;
                end
            end
            if (found)
            begin
                seen_tab[slot] = w.now_seconds;
                refreshes++;
            end
            else if (hosts < TABLE_DEPTH)
            begin
                slot           = hosts;
                ip_tab[slot]   = w.src_ip;
                mac_tab[slot]  = w.src_mac;
                seen_tab[slot] = w.now_seconds;
                hosts++;
                learned++;
            end
            else
            begin
                dropped = 1'b1;
                drops++;
            end
            r.hit          = found;
            r.entry_index  = 6'(slot);
            r.host_total   = 7'(hosts);
            r.dropped_full = dropped;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned exp_v, int unsigned got_v);
            if (exp_v != got_v)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(ahlt_out_t got);
            ahlt_out_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("hit", want.hit, got.hit);
            compare_field("entry_index", want.entry_index, got.entry_index);
            compare_field("host_total", want.host_total, got.host_total);
            compare_field("dropped_full", want.dropped_full, got.dropped_full);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ahlt_in_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    ahlt_out_t out_data;

    host_table_scoreboard sb = new();

    int unsigned burst_left;
    int unsigned rcv_cycle = 0;
    int unsigned rcv_mode = 0;

    arp_host_learning_table_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: always ready, random, or mostly stalled, in a mode picked again at random as the run goes
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result(out_data);
        rcv_cycle = rcv_cycle + 1;
        if (rcv_cycle % 64 == 0)
            rcv_mode = $urandom_range(0, 2);
        case (rcv_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (rcv_cycle % 16) < 4;
        endcase
    end

    function automatic ahlt_in_t frame(logic [15:0] ft, logic [31:0] ip,
                                       logic [47:0] mac, logic [31:0] now);
        ahlt_in_t w;
        w.frame_type  = ft;
        w.src_ip      = ip;
        w.src_mac     = mac;
        w.now_seconds = now;
        return w;
    endfunction

    task automatic send_frame(ahlt_in_t w);
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_frame(w);
        if (burst_left > 1)
            burst_left--;
        else
        begin
            in_valid   <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic ahlt_in_t random_frame();
        logic [15:0] ft;
        logic [31:0] ip;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            ft = 16'($urandom);
            if (ft == ARP_TYPE)
                ft = ft ^ 16'h0001;
        end
        else if (pick < 12)
            ft = ARP_TYPE ^ (16'h0001 << $urandom_range(0, 15));
        else
            ft = ARP_TYPE;
        if (sb.hosts > 0 && $urandom_range(0, 1))
            ip = sb.ip_tab[$urandom_range(0, sb.hosts - 1)];
        else
            ip = $urandom;
        return frame(ft, ip, 48'({$urandom, $urandom}), $urandom);
    endfunction

    initial
    begin
        ahlt_in_t    w;
        int unsigned sent;
        sent       = 0;
        burst_left = 4;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // non-arp ethertypes
        send_frame(frame(16'h0000, 32'h0, 48'h0, 32'h0));
        send_frame(frame(16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_frame(frame(16'h0807, 32'h0A00_0001, 48'h0200_0000_0001, 32'd1));
        send_frame(frame(16'h0800, 32'h0A00_0002, 48'h0200_0000_0002, 32'd2));
        send_frame(frame(16'h86DD, 32'h0A00_0003, 48'h0200_0000_0003, 32'd3));
        send_frame(frame(16'hF7F9, 32'h0A00_0004, 48'h0200_0000_0004, 32'd4));
        // new hosts at the field extremes
        send_frame(frame(ARP_TYPE, 32'h0, 48'h0, 32'h0));
        send_frame(frame(ARP_TYPE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        // refreshes keep the stored mac; one new host is learned among them
        send_frame(frame(ARP_TYPE, 32'h0, 48'hFFFF_FFFF_FFFF, 32'd5));
        send_frame(frame(ARP_TYPE, 32'hFFFF_FFFF, 48'h0, 32'h0));
        send_frame(frame(ARP_TYPE, 32'hC0A8_0101, 48'h0011_2233_4455, 32'h8000_0000));
        send_frame(frame(ARP_TYPE, 32'hC0A8_0101, 48'h0011_2233_4455, 32'h8000_0001));
        send_frame(frame(ARP_TYPE, 32'h0, 48'h0, 32'h7FFF_FFFF));
        sent = 13;
        drain_results();

        // random traffic: the table fills, then refreshes mix with drops
        while (sent < 1100)
        begin
            w = random_frame();
            send_frame(w);
            sent++;
            if (sent % 250 == 0)
                drain_results();
        end

        drain_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        $display("covered %0d arp words: %0d new hosts, %0d refreshes, %0d dropped on full table",
                 sb.checked, sb.learned, sb.refreshes, sb.drops);
        $display("%0d other frames ignored, %0d hosts held at the end", sb.others, sb.hosts);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS arp_host_learning_table_core");
        else
            $display("FAIL arp_host_learning_table_core");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("FAIL arp_host_learning_table_core");
        $finish;
    end

endmodule

[arp_host_learning_table_core.f]
hw/rtl/ahlt_pkg.sv
hw/rtl/ahlt_ctrl.sv
hw/rtl/ahlt_dp.sv
hw/rtl/arp_host_learning_table_core.sv
dv/arp_host_learning_table_core_tb.sv
